>>> hw/rtl/rbcl_pkg.sv
// ----------------------------------------------------------------------------
// rbcl_pkg
// Shared types, codes and step functions for the ray/box chord length core.
// ----------------------------------------------------------------------------
package rbcl_pkg;

  localparam int CW = 32;           // coordinate width
  localparam int HW = 31;           // half size and chord width
  localparam int AW = 34;           // slab numerator magnitude width
  localparam int RW = 36;           // square root remainder width
  localparam int PW = 66;           // product and dividend width
  localparam int SQ_STAGES = 16;    // two root bits per stage
  localparam int DIV_STAGES = 33;   // two quotient bits per stage
  localparam int NSLAB = 6;

  localparam logic [62:0] T_SAT = 63'h4000_0000_0000_0000;
  localparam logic [HW-1:0] CHORD_MAX = {HW{1'b1}};

  typedef logic [2:0] status_t;
  localparam status_t ST_HIT      = 3'd0;
  localparam status_t ST_NONE     = 3'd1;
  localparam status_t ST_GROUND   = 3'd2;
  localparam status_t ST_NOT_BOX  = 3'd3;
  localparam status_t ST_PARALLEL = 3'd4;
  localparam status_t ST_MISS     = 3'd5;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE   = 2'd0;
  localparam kind_t KIND_GROUND = 2'd1;
  localparam kind_t KIND_BOX    = 2'd2;
  localparam kind_t KIND_OTHER  = 2'd3;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CENTER_X = 3'd0;
  localparam cfg_idx_t CFG_CENTER_Y = 3'd1;
  localparam cfg_idx_t CFG_CENTER_Z = 3'd2;
  localparam cfg_idx_t CFG_HALF_X   = 3'd3;
  localparam cfg_idx_t CFG_HALF_Y   = 3'd4;
  localparam cfg_idx_t CFG_HALF_Z   = 3'd5;
  localparam cfg_idx_t CFG_KIND     = 3'd6;

  // per-request side information that rides along the pipeline
  typedef struct packed {
    status_t    st;    // early status, ST_HIT while still undecided
    logic [2:0] dz;    // axis direction is zero
    logic [5:0] neg;   // slab distance is negative
  } meta_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [31:0]   root;
  } sqrt_st_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [1:0]  qb;
  } div_st_t;

  // two bits of a digit-by-digit integer square root
  function automatic sqrt_st_t sqrt_step2(input logic [RW-1:0] rem,
                                          input logic [31:0] root,
                                          input logic [3:0] bits);
    logic [RW-1:0] t;
    logic [RW-1:0] tr;
    logic [31:0]   q;
    sqrt_st_t      res;
    t = {rem[RW-3:0], bits[3:2]};
    tr = {2'b00, root, 2'b01};
    q = root;
    if (t >= tr) begin
      t = t - tr;
      q = {q[30:0], 1'b1};
    end else begin
      q = {q[30:0], 1'b0};
    end
    t = {t[RW-3:0], bits[1:0]};
    tr = {2'b00, q, 2'b01};
    if (t >= tr) begin
      t = t - tr;
      q = {q[30:0], 1'b1};
    end else begin
      q = {q[30:0], 1'b0};
    end
    res.rem = t;
    res.root = q;
    return res;
  endfunction

  // two bits of restoring division
  function automatic div_st_t div_step2(input logic [31:0] rem,
                                        input logic [31:0] den,
                                        input logic [1:0] bits);
    logic [32:0] t;
    div_st_t     res;
    t = {rem, bits[1]};
    res.qb[1] = (t >= {1'b0, den});
    if (res.qb[1]) begin
      t = t - {1'b0, den};
    end
    t = {t[31:0], bits[0]};
    res.qb[0] = (t >= {1'b0, den});
    if (res.qb[0]) begin
      t = t - {1'b0, den};
    end
    res.rem = t[31:0];
    return res;
  endfunction

endpackage

>>> hw/rtl/ray_box_chord_length_core.sv
// ----------------------------------------------------------------------------
// ray_box_chord_length_core
// Slab-method ray against axis-aligned box test returning the chord length.
// ----------------------------------------------------------------------------
// Takes one ray request per clock while in_stall is low and returns one
// result per request, in order. The depth is set by the 16-stage square
// root of the direction length (two root bits per stage) and the 33-stage
// dividers of the six slab distances (two quotient bits per stage). A stall
// on the output freezes the whole pipeline and raises in_stall in the same
// cycle. The user must write box registers only while no request is in
// flight; the block itself does not enforce this.
module ray_box_chord_length_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_ray_origin_x,
  input  logic signed [31:0]            in_ray_origin_y,
  input  logic signed [31:0]            in_ray_origin_z,
  input  logic signed [31:0]            in_ray_dir_x,
  input  logic signed [31:0]            in_ray_dir_y,
  input  logic signed [31:0]            in_ray_dir_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [30:0]                   out_chord_length,
  output logic [2:0]                    out_hit_status
);

  localparam int SQN = rbcl_pkg::SQ_STAGES;
  localparam int DVN = rbcl_pkg::DIV_STAGES;

  // configuration registers
  logic signed [31:0] cfg_center_r [0:2];
  logic [30:0]        cfg_half_r [0:2];
  rbcl_pkg::kind_t    cfg_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cfg_center_r[i] <= '0;
        cfg_half_r[i] <= '0;
      end
      cfg_kind_r <= rbcl_pkg::KIND_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        rbcl_pkg::CFG_CENTER_X: cfg_center_r[0] <= cfg_wdata;
        rbcl_pkg::CFG_CENTER_Y: cfg_center_r[1] <= cfg_wdata;
        rbcl_pkg::CFG_CENTER_Z: cfg_center_r[2] <= cfg_wdata;
        rbcl_pkg::CFG_HALF_X:   cfg_half_r[0] <= cfg_wdata[30:0];
        rbcl_pkg::CFG_HALF_Y:   cfg_half_r[1] <= cfg_wdata[30:0];
        rbcl_pkg::CFG_HALF_Z:   cfg_half_r[2] <= cfg_wdata[30:0];
        rbcl_pkg::CFG_KIND:     cfg_kind_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the output holds a stalled result
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // entry stage: slab bounds, numerators, parallel check, early status
  logic signed [31:0] p_in [0:2];
  logic signed [31:0] d_in [0:2];
  assign p_in[0] = in_ray_origin_x;
  assign p_in[1] = in_ray_origin_y;
  assign p_in[2] = in_ray_origin_z;
  assign d_in[0] = in_ray_dir_x;
  assign d_in[1] = in_ray_dir_y;
  assign d_in[2] = in_ray_dir_z;

  rbcl_pkg::meta_t a_meta_nxt;
  logic [33:0]     a_amag_nxt [0:5];
  logic [31:0]     a_dmag_nxt [0:2];

  always_comb begin
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] p34;
    logic signed [33:0] nlo;
    logic signed [33:0] nhi;
    logic               par_miss;
    par_miss = 1'b0;
    a_meta_nxt.dz = '0;
    a_meta_nxt.neg = '0;
    for (int i = 0; i < 3; i++) begin
      lo = {{2{cfg_center_r[i][31]}}, cfg_center_r[i]} - {3'b000, cfg_half_r[i]};
      hi = {{2{cfg_center_r[i][31]}}, cfg_center_r[i]} + {3'b000, cfg_half_r[i]};
      p34 = {{2{p_in[i][31]}}, p_in[i]};
      nlo = lo - p34;
      nhi = hi - p34;
      a_meta_nxt.dz[i] = (d_in[i] == '0);
      a_meta_nxt.neg[2*i] = nlo[33] ^ d_in[i][31];
      a_meta_nxt.neg[2*i+1] = nhi[33] ^ d_in[i][31];
      a_amag_nxt[2*i] = nlo[33] ? 34'(-nlo) : 34'(nlo);
      a_amag_nxt[2*i+1] = nhi[33] ? 34'(-nhi) : 34'(nhi);
      a_dmag_nxt[i] = d_in[i][31] ? 32'(-d_in[i]) : 32'(d_in[i]);
      if (a_meta_nxt.dz[i] && ((p34 < lo) || (p34 > hi))) begin
        par_miss = 1'b1;
      end
    end
    case (cfg_kind_r)
      rbcl_pkg::KIND_NONE:   a_meta_nxt.st = rbcl_pkg::ST_NONE;
      rbcl_pkg::KIND_GROUND: a_meta_nxt.st = rbcl_pkg::ST_GROUND;
      rbcl_pkg::KIND_BOX:
        a_meta_nxt.st = par_miss ? rbcl_pkg::ST_PARALLEL : rbcl_pkg::ST_HIT;
      default:               a_meta_nxt.st = rbcl_pkg::ST_NOT_BOX;
    endcase
  end

  // stage registers
  logic            a_vld_r, b_vld_r;
  rbcl_pkg::meta_t a_meta_r, b_meta_r;
  logic [33:0]     a_amag_r [0:5];
  logic [33:0]     b_amag_r [0:5];
  logic [31:0]     a_dmag_r [0:2];
  logic [31:0]     b_dmag_r [0:2];
  logic [63:0]     b_sq_r [0:2];

  logic            sq_vld_r [0:SQN];
  rbcl_pkg::meta_t sq_meta_r [0:SQN];
  logic [33:0]     sq_amag_r [0:SQN][0:5];
  logic [31:0]     sq_dmag_r [0:SQN][0:2];
  logic [35:0]     sq_rem_r [0:SQN];
  logic [31:0]     sq_root_r [0:SQN];
  logic [63:0]     sq_x_r [0:SQN];

  logic            dv_vld_r [0:DVN];
  rbcl_pkg::meta_t dv_meta_r [0:DVN];
  logic [31:0]     dv_den_r [0:DVN][0:5];
  logic [65:0]     dv_num_r [0:DVN][0:5];
  logic [31:0]     dv_rem_r [0:DVN][0:5];
  logic [65:0]     dv_q_r [0:DVN][0:5];

  logic               f1_vld_r, f2_vld_r;
  rbcl_pkg::meta_t    f1_meta_r;
  logic signed [63:0] f1_tlo_r [0:2];
  logic signed [63:0] f1_thi_r [0:2];
  rbcl_pkg::status_t  f2_st_r;
  logic signed [63:0] f2_tmin_r, f2_tmax_r;

  logic              out_valid_r;
  logic [30:0]       out_chord_r;
  rbcl_pkg::status_t out_status_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      for (int k = 0; k <= SQN; k++) begin
        sq_vld_r[k] <= 1'b0;
      end
      for (int k = 0; k <= DVN; k++) begin
        dv_vld_r[k] <= 1'b0;
      end
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      sq_vld_r[0] <= b_vld_r;
      for (int k = 1; k <= SQN; k++) begin
        sq_vld_r[k] <= sq_vld_r[k-1];
      end
      dv_vld_r[0] <= sq_vld_r[SQN];
      for (int k = 1; k <= DVN; k++) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
      f1_vld_r <= dv_vld_r[DVN];
      f2_vld_r <= f1_vld_r;
      out_valid_r <= f2_vld_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rbcl_pkg::sqrt_st_t sres;
    rbcl_pkg::div_st_t  dres;
    logic [63:0]        plo;
    logic [33:0]        phi;
    logic [62:0]        qm;
    logic signed [63:0] t1;
    logic signed [63:0] t2;
    logic signed [63:0] tmin;
    logic signed [63:0] tmax;
    logic signed [63:0] entry;
    logic signed [63:0] chord;
    if (adv) begin
      // entry
      a_meta_r <= a_meta_nxt;
      for (int i = 0; i < 6; i++) begin
        a_amag_r[i] <= a_amag_nxt[i];
      end
      for (int i = 0; i < 3; i++) begin
        a_dmag_r[i] <= a_dmag_nxt[i];
      end

      // squares of the direction components
      b_meta_r <= a_meta_r;
      for (int i = 0; i < 6; i++) begin
        b_amag_r[i] <= a_amag_r[i];
      end
      for (int i = 0; i < 3; i++) begin
        b_dmag_r[i] <= a_dmag_r[i];
        b_sq_r[i] <= {32'h0, a_dmag_r[i]} * {32'h0, a_dmag_r[i]};
      end

      // sum of squares seeds the root
      sq_meta_r[0] <= b_meta_r;
      sq_amag_r[0] <= b_amag_r;
      sq_dmag_r[0] <= b_dmag_r;
      sq_rem_r[0] <= '0;
      sq_root_r[0] <= '0;
      sq_x_r[0] <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];

      // square root, two bits per stage
      for (int k = 1; k <= SQN; k++) begin
        sres = rbcl_pkg::sqrt_step2(sq_rem_r[k-1], sq_root_r[k-1], sq_x_r[k-1][63:60]);
        sq_rem_r[k] <= sres.rem;
        sq_root_r[k] <= sres.root;
        sq_x_r[k] <= {sq_x_r[k-1][59:0], 4'b0000};
        sq_meta_r[k] <= sq_meta_r[k-1];
        sq_amag_r[k] <= sq_amag_r[k-1];
        sq_dmag_r[k] <= sq_dmag_r[k-1];
      end

      // numerator times direction length, split into partial products
      dv_meta_r[0] <= sq_meta_r[SQN];
      for (int s = 0; s < 6; s++) begin
        plo = {32'h0, sq_amag_r[SQN][s][31:0]} * {32'h0, sq_root_r[SQN]};
        phi = {32'h0, sq_amag_r[SQN][s][33:32]} * {2'b00, sq_root_r[SQN]};
        dv_num_r[0][s] <= {2'b00, plo} + {phi, 32'h0};
        dv_den_r[0][s] <= (sq_dmag_r[SQN][s/2] == '0) ? 32'd1 : sq_dmag_r[SQN][s/2];
        dv_rem_r[0][s] <= '0;
        dv_q_r[0][s] <= '0;
      end

      // six dividers, two quotient bits per stage
      for (int k = 1; k <= DVN; k++) begin
        dv_meta_r[k] <= dv_meta_r[k-1];
        for (int s = 0; s < 6; s++) begin
          dres = rbcl_pkg::div_step2(dv_rem_r[k-1][s], dv_den_r[k-1][s],
                                     dv_num_r[k-1][s][65:64]);
          dv_rem_r[k][s] <= dres.rem;
          dv_q_r[k][s] <= {dv_q_r[k-1][s][63:0], dres.qb};
          dv_num_r[k][s] <= {dv_num_r[k-1][s][63:0], 2'b00};
          dv_den_r[k][s] <= dv_den_r[k-1][s];
        end
      end

      // signed, saturated slab distances ordered per axis
      f1_meta_r <= dv_meta_r[DVN];
      for (int i = 0; i < 3; i++) begin
        qm = (dv_q_r[DVN][2*i] >= {3'b000, rbcl_pkg::T_SAT}) ? rbcl_pkg::T_SAT
             : dv_q_r[DVN][2*i][62:0];
        t1 = dv_meta_r[DVN].neg[2*i] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        qm = (dv_q_r[DVN][2*i+1] >= {3'b000, rbcl_pkg::T_SAT}) ? rbcl_pkg::T_SAT
             : dv_q_r[DVN][2*i+1][62:0];
        t2 = dv_meta_r[DVN].neg[2*i+1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        if (dv_meta_r[DVN].dz[i]) begin
          f1_tlo_r[i] <= {1'b1, 63'h0};
          f1_thi_r[i] <= {1'b0, {63{1'b1}}};
        end else if (t1 > t2) begin
          f1_tlo_r[i] <= t2;
          f1_thi_r[i] <= t1;
        end else begin
          f1_tlo_r[i] <= t1;
          f1_thi_r[i] <= t2;
        end
      end

      // interval intersection and miss test
      tmin = f1_tlo_r[0];
      tmax = f1_thi_r[0];
      for (int i = 1; i < 3; i++) begin
        if (f1_tlo_r[i] > tmin) tmin = f1_tlo_r[i];
        if (f1_thi_r[i] < tmax) tmax = f1_thi_r[i];
      end
      f2_tmin_r <= tmin;
      f2_tmax_r <= tmax;
      if (f1_meta_r.st != rbcl_pkg::ST_HIT) begin
        f2_st_r <= f1_meta_r.st;
      end else if ((tmax < tmin) || (tmax < 0)) begin
        f2_st_r <= rbcl_pkg::ST_MISS;
      end else begin
        f2_st_r <= rbcl_pkg::ST_HIT;
      end

      // chord from clamped entry to exit, saturated
      entry = (f2_tmin_r > 0) ? f2_tmin_r : 64'sd0;
      chord = f2_tmax_r - entry;
      out_status_r <= f2_st_r;
      if (f2_st_r != rbcl_pkg::ST_HIT) begin
        out_chord_r <= '0;
      end else if (chord > $signed({33'h0, rbcl_pkg::CHORD_MAX})) begin
        out_chord_r <= rbcl_pkg::CHORD_MAX;
      end else begin
        out_chord_r <= chord[30:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_chord_length = out_chord_r;
  assign out_hit_status = out_status_r;

  // a result that is not a hit carries no chord
  a_no_chord_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hit_status != rbcl_pkg::ST_HIT) |-> out_chord_length == '0)
    else $error("chord length set on a non-hit result");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_status <= rbcl_pkg::ST_MISS)
    else $error("undefined hit status");

  // remainders of the first and last dividers end below the denominator
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[DVN] |-> (dv_rem_r[DVN][0] < dv_den_r[DVN][0]) &&
                      (dv_rem_r[DVN][5] < dv_den_r[DVN][5]))
    else $error("divider remainder out of range");

  // a stalled result freezes the entry and f2 valid bits of the pipeline
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(a_vld_r) && $stable(f2_vld_r))
    else $error("pipeline moved under output stall");

endmodule
